### src/utxcts_pkg.sv
// Shared types and constants for the UART transmit FIFO with CTS pacing.
// No dependencies; used by utxcts_fifo and uart_tx_fifo_cts_flow_control.

package utxcts_pkg;

    // Default queue depth; the queue holds at most depth minus one bytes
    localparam int FIFO_DEPTH_DEF = 128;

    localparam int BYTE_W = 8;
    localparam int FILL_W = 7;

    // Codes of the action field
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READY = 2'd1,
        ACT_CTS   = 2'd2
    } action_t;

    // Up to two pushes in one cycle; slot 1 is used only together with slot 0
    typedef struct packed {
        logic              en0;
        logic [BYTE_W-1:0] data0;
        logic              en1;
        logic [BYTE_W-1:0] data1;
    } push_t;

endpackage

### src/utxcts_fifo.sv
// Byte queue with two pushes and one pop per cycle, stored in two interleaved banks.
// The oldest byte is prefetched into registers every cycle. Depends on utxcts_pkg.

module utxcts_fifo #(
    parameter int DEPTH = utxcts_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  utxcts_pkg::push_t              push,
    input  logic                           pop,
    output logic [$clog2(DEPTH)-1:0]       count,
    output logic [utxcts_pkg::BYTE_W-1:0]  head
);

    localparam int AW         = $clog2(DEPTH);
    localparam int BANK_DEPTH = (DEPTH + 1) / 2;
    localparam int BW         = $clog2(BANK_DEPTH);
    localparam int DW         = utxcts_pkg::BYTE_W;

    // Logical pointers, modulo DEPTH, for the fill count
    logic [AW-1:0] wp_reg, wp_next, wp_one;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW:0]   diff;

    // Bank selects and per-bank addresses, modulo BANK_DEPTH
    logic          wr_sel_reg, wr_sel_next;
    logic          rd_sel_reg, rd_sel_next;
    logic [BW-1:0] wa_reg [2];
    logic [BW-1:0] wa_next [2];
    logic [BW-1:0] ra_reg [2];
    logic [BW-1:0] ra_next [2];

    logic          we [2];
    logic [DW-1:0] wdata [2];
    logic [DW-1:0] head_w [2];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [BW-1:0] addr_inc(input logic [BW-1:0] a);
        addr_inc = (a == BW'(BANK_DEPTH - 1)) ? '0 : a + BW'(1);
    endfunction

    // Route slot 0 to the current write bank and slot 1 to the other one
    always_comb
    begin
        we[0]    = (push.en0 && !wr_sel_reg) || (push.en1 && wr_sel_reg);
        we[1]    = (push.en0 && wr_sel_reg) || (push.en1 && !wr_sel_reg);
        wdata[0] = (push.en0 && !wr_sel_reg) ? push.data0 : push.data1;
        wdata[1] = (push.en0 && wr_sel_reg) ? push.data0 : push.data1;
    end

    // Advance pointers and bank addresses
    always_comb
    begin
        wp_one      = push.en0 ? ptr_inc(wp_reg) : wp_reg;
        wp_next     = push.en1 ? ptr_inc(wp_one) : wp_one;
        rp_next     = pop ? ptr_inc(rp_reg) : rp_reg;
        wr_sel_next = wr_sel_reg ^ push.en0 ^ push.en1;
        rd_sel_next = rd_sel_reg ^ pop;
        for (int b = 0; b < 2; b++)
        begin
            wa_next[b] = we[b] ? addr_inc(wa_reg[b]) : wa_reg[b];
            ra_next[b] = (pop && (rd_sel_reg == 1'(b))) ? addr_inc(ra_reg[b]) : ra_reg[b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            for (int b = 0; b < 2; b++)
            begin
                wa_reg[b] <= '0;
                ra_reg[b] <= '0;
            end
        end
        else
        begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            for (int b = 0; b < 2; b++)
            begin
                wa_reg[b] <= wa_next[b];
                ra_reg[b] <= ra_next[b];
            end
        end
    end

    // Storage banks; read the next head address every cycle, bypass a same-cycle write
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        logic [DW-1:0] mem [BANK_DEPTH];
        logic [DW-1:0] rd_data_reg;
        logic [DW-1:0] byp_data_reg;
        logic          byp_vld_reg;

        always_ff @(posedge clk)
        begin
            if (we[b])
            begin
                mem[wa_reg[b]] <= wdata[b];
            end
            rd_data_reg  <= mem[ra_next[b]];
            byp_data_reg <= wdata[b];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                byp_vld_reg <= 1'b0;
            end
            else
            begin
                byp_vld_reg <= we[b] && (wa_reg[b] == ra_next[b]);
            end
        end

        assign head_w[b] = byp_vld_reg ? byp_data_reg : rd_data_reg;
    end

    assign head = rd_sel_reg ? head_w[1] : head_w[0];

    // Fill count, modulo DEPTH
    always_comb
    begin
        diff = {1'b0, wp_reg} - {1'b0, rp_reg};
        if (diff[AW])
        begin
            count = AW'(diff + (AW + 1)'(DEPTH));
        end
        else
        begin
            count = diff[AW-1:0];
        end
    end

endmodule

### src/uart_tx_fifo_cts_flow_control.sv
// Pipeline: the accepting edge loads the input register, and the edge on which the word advances
// loads its result into the result register, which drives the outputs; one word is accepted
// per cycle while the output is not stalled, as all per-word work is a single pass of flag logic
// and the queue's head byte is prefetched from its banks.
// Reset: queue empty, transmitter not idle, CTS on, flow control off; no clearing pass,
// the byte storage keeps no reset and every entry is written before it is read.

module uart_tx_fifo_cts_flow_control #(
    parameter int FIFO_DEPTH = utxcts_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [utxcts_pkg::BYTE_W-1:0]  first_byte,
    input  logic [utxcts_pkg::BYTE_W-1:0]  second_byte,
    input  logic                           has_second,
    input  logic                           cts_line,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           tx_valid,
    output logic [utxcts_pkg::BYTE_W-1:0]  tx_byte,
    output logic                           dropped,
    output logic [utxcts_pkg::FILL_W-1:0]  fill_level
);

    localparam int CW = $clog2(FIFO_DEPTH);
    localparam int DW = utxcts_pkg::BYTE_W;

    // Input register
    logic          in_vld_reg;
    logic [1:0]    act_reg;
    logic [DW-1:0] first_reg;
    logic [DW-1:0] second_reg;
    logic          has2_reg;
    logic          line_reg;

    // Control state
    logic flow_reg;
    logic idle_reg, idle_next;
    logic cts_reg, cts_next;

    // Result register
    logic          out_vld_reg;
    logic          tx_vld_reg, tx_vld_next;
    logic [DW-1:0] tx_byte_reg, tx_byte_next;
    logic          drop_reg, drop_next;
    logic [utxcts_pkg::FILL_W-1:0] fill_reg, fill_next;

    logic              advance;
    logic              cts_ok;
    logic              full0;
    logic              full1;
    logic              send_first;
    logic              acc1;
    logic              acc2;
    logic              pop_req;
    utxcts_pkg::push_t push_req;
    utxcts_pkg::push_t push;
    logic              pop;
    logic [CW-1:0]     count;
    logic [DW-1:0]     head;
    logic [CW:0]       count_after;
    utxcts_pkg::action_t act;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign cfg_ready = 1'b1;

    // Hold the incoming word
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            act_reg    <= action;
            first_reg  <= first_byte;
            second_reg <= second_byte;
            has2_reg   <= has_second;
            line_reg   <= cts_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    utxcts_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .count (count),
        .head  (head)
    );

    // Decide send, queue and drop for the held word
    always_comb
    begin
        act          = utxcts_pkg::action_t'(act_reg);
        cts_ok       = !flow_reg || cts_reg;
        full0        = count >= CW'(FIFO_DEPTH - 1);
        full1        = count >= CW'(FIFO_DEPTH - 2);
        send_first   = 1'b0;
        acc1         = 1'b0;
        acc2         = 1'b0;
        pop_req      = 1'b0;
        idle_next    = idle_reg;
        cts_next     = cts_reg;
        tx_vld_next  = 1'b0;
        tx_byte_next = '0;
        drop_next    = 1'b0;

        unique case (act)
            utxcts_pkg::ACT_WRITE:
            begin
                send_first = idle_reg && cts_ok;
                if (send_first)
                begin
                    idle_next    = 1'b0;
                    tx_vld_next  = 1'b1;
                    tx_byte_next = first_reg;
                    if (flow_reg)
                    begin
                        cts_next = 1'b0;
                    end
                end
                else
                begin
                    acc1 = !full0;
                end
                if (has2_reg)
                begin
                    acc2 = acc1 ? !full1 : !full0;
                end
                drop_next = (!send_first && !acc1) || (has2_reg && !acc2);
            end
            utxcts_pkg::ACT_READY:
            begin
                if (count == '0 || !cts_ok)
                begin
                    idle_next = 1'b1;
                end
                else
                begin
                    pop_req      = 1'b1;
                    tx_vld_next  = 1'b1;
                    tx_byte_next = head;
                    if (flow_reg)
                    begin
                        cts_next = 1'b0;
                    end
                end
            end
            utxcts_pkg::ACT_CTS:
            begin
                if (line_reg)
                begin
                    if (count != '0 && idle_reg)
                    begin
                        pop_req      = 1'b1;
                        tx_vld_next  = 1'b1;
                        tx_byte_next = head;
                        idle_next    = 1'b0;
                    end
                    else
                    begin
                        cts_next = 1'b1;
                    end
                end
            end
            default:
            begin
                idle_next = idle_reg;
            end
        endcase

        // Pack queue writes: the first accepted byte always takes slot 0
        push_req.en0   = acc1 || acc2;
        push_req.data0 = acc1 ? first_reg : second_reg;
        push_req.en1   = acc1 && acc2;
        push_req.data1 = second_reg;

        count_after = {1'b0, count} + (CW + 1)'(push_req.en0) + (CW + 1)'(push_req.en1)
                      - (CW + 1)'(pop_req);
        fill_next   = utxcts_pkg::FILL_W'(count_after);
    end

    // Queue updates only when the word moves on
    always_comb
    begin
        push     = push_req;
        push.en0 = push_req.en0 && advance;
        push.en1 = push_req.en1 && advance;
        pop      = pop_req && advance;
    end

    // Hold control state and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg    <= 1'b0;
            idle_reg    <= 1'b0;
            cts_reg     <= 1'b1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                flow_reg <= cfg_data;
            end
            if (advance)
            begin
                idle_reg    <= idle_next;
                cts_reg     <= cts_next;
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_vld_reg  <= tx_vld_next;
            tx_byte_reg <= tx_byte_next;
            drop_reg    <= drop_next;
            fill_reg    <= fill_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign tx_valid   = tx_vld_reg;
    assign tx_byte    = tx_byte_reg;
    assign dropped    = drop_reg;
    assign fill_level = fill_reg;

    // A pop is never issued against an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count != '0)
        else $error("pop issued on empty queue");

    // Two pushes in a cycle only when the queue has room for both
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.en1 |-> count < CW'(FIFO_DEPTH - 2))
        else $error("double push overflows queue");

    // A direct send on the write path leaves the transmitter busy
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && act_reg == utxcts_pkg::ACT_WRITE && send_first) |=> !idle_reg)
        else $error("transmitter still idle after direct send");

    // A sent byte reaches the result register on the next edge
    a_send_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tx_vld_next) |=> (out_valid && tx_valid))
        else $error("sent byte missing from result");

endmodule
